@@ rtl/mice_pkg.sv @@
// ----------------------------------------------------------------------------
// Mic-E encoder package
// Shared types, register codes, character constants and reciprocal constants
// for the Mic-E position encoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mice_pkg;

  // APB register file
  localparam int unsigned CfgAddrW = 3;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned SymW     = 7;

  localparam logic [SymW-1:0] SymCodeRst  = 7'd79;  // 'O'
  localparam logic [SymW-1:0] SymTableRst = 7'd47;  // '/'

  typedef enum logic [0:0] {
    RegSymbolCode  = 1'b0,
    RegSymbolTable = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic [SymW-1:0] symbol_code;
    logic [SymW-1:0] symbol_table;
  } cfg_t;

  // Pipeline depth from input to output (seven lane stages, digit stage, output)
  localparam int unsigned PipeDepth = 9;

  // Characters and offsets
  localparam logic [7:0] CharTick  = 8'h60;  // '`'
  localparam logic [7:0] CharBrace = 8'h7D;  // '}'
  localparam logic [7:0] CharP     = 8'h50;  // 'P'
  localparam logic [7:0] Char0     = 8'h30;  // '0'
  localparam logic [7:0] FlagOfs   = CharP - Char0;
  localparam logic [7:0] Base91Ofs = 8'd33;
  localparam logic [7:0] ByteOfs   = 8'd28;
  localparam logic [7:0] LonOfsLo  = 8'd118;
  localparam logic [7:0] LonOfsMid = 8'd28;
  localparam logic [7:0] LonOfsHi  = 8'd8;
  localparam logic [7:0] LonOfsTop = 8'd72;
  localparam logic [7:0] MinOfsLo  = 8'd88;
  localparam logic [7:0] MinOfsHi  = 8'd28;

  // Altitude datum and saturation, meters
  localparam logic signed [22:0] AltDatum = 23'sd10000;
  localparam logic [19:0]        AltMax   = 20'd753570;

  // Scale of the angle inputs
  localparam logic [31:0] DegScale = 32'd10000000;

  // Reciprocals: q = (x * ceil(2^s / d)) >> s, exact for the input ranges used
  localparam logic [31:0] RecipDeg    = 32'(((64'd1 << 55) + 64'(DegScale) - 64'd1)
                                            / 64'(DegScale));
  localparam logic [26:0] RecipMin    = 27'(((64'd1 << 40) + 64'd9999) / 64'd10000);
  localparam logic [13:0] Recip100T   = 14'(((64'd1 << 20) + 64'd99) / 64'd100);
  localparam logic [13:0] Recip10Spd  = 14'(((64'd1 << 17) + 64'd9) / 64'd10);
  localparam logic [16:0] Recip100Hdg = 17'(((64'd1 << 23) + 64'd99) / 64'd100);
  localparam logic [10:0] Recip100Sm  = 11'(((64'd1 << 17) + 64'd99) / 64'd100);
  localparam logic [27:0] RecipAlt    = 28'(((64'd1 << 34) + 64'd99) / 64'd100);
  localparam logic [20:0] Recip91     = 21'(((64'd1 << 27) + 64'd90) / 64'd91);
  localparam logic [14:0] Recip91Sm   = 15'(((64'd1 << 21) + 64'd90) / 64'd91);
  localparam logic [7:0]  Recip10     = 8'(((64'd1 << 11) + 64'd9) / 64'd10);

  // Result of one coordinate lane
  typedef struct packed {
    logic [7:0] deg;   // whole degrees
    logic [5:0] mins;  // whole minutes
    logic [6:0] hund;  // hundredths of a minute
    logic       pos;   // value above zero
    logic       neg;   // value below zero
  } coord_res_t;

  // Result of the speed, heading and altitude lane
  typedef struct packed {
    logic [6:0] spd_hund;    // speed / 100
    logic [3:0] knot_units;  // (speed / 10) % 10
    logic [2:0] hdg_thou;    // heading / 10000
    logic [6:0] hdg_rem;     // (heading / 100) % 100
    logic [6:0] alt_hi;
    logic [6:0] alt_mid;
    logic [6:0] alt_lo;
  } motion_res_t;

  // Quotient by ten of a byte
  function automatic logic [4:0] div10(input logic [7:0] x);
    logic [15:0] p;
    p = 16'(x) * 16'(Recip10);
    return p[15:11];
  endfunction

endpackage

@@ rtl/mice_cfg.sv @@
// ----------------------------------------------------------------------------
// Mic-E configuration registers
// APB register file holding the symbol code and symbol table characters.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mice_cfg (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [mice_pkg::CfgAddrW-1:0]   paddr,
  input  logic [mice_pkg::CfgDataW-1:0]   pwdata,
  output logic [mice_pkg::CfgDataW-1:0]   prdata,
  output logic                            pready,
  output mice_pkg::cfg_t                  cfg_o
);
  import mice_pkg::*;

  cfg_reg_e        reg_sel;
  logic            wr_en;
  logic [SymW-1:0] code_q, code_d;
  logic [SymW-1:0] table_q, table_d;

  assign pready  = 1'b1;
  assign reg_sel = cfg_reg_e'(paddr[2]);
  assign wr_en   = psel & penable & pwrite & pready;

  // Write decode
  always_comb begin
    code_d  = code_q;
    table_d = table_q;
    if (wr_en) begin
      unique case (reg_sel)
        RegSymbolCode:  code_d  = pwdata[SymW-1:0];
        RegSymbolTable: table_d = pwdata[SymW-1:0];
        default:        code_d  = code_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      code_q  <= SymCodeRst;
      table_q <= SymTableRst;
    end else begin
      code_q  <= code_d;
      table_q <= table_d;
    end
  end

  // Read mux
  always_comb begin
    unique case (reg_sel)
      RegSymbolCode:  prdata = CfgDataW'(code_q);
      RegSymbolTable: prdata = CfgDataW'(table_q);
      default:        prdata = '0;
    endcase
  end

  assign cfg_o.symbol_code  = code_q;
  assign cfg_o.symbol_table = table_q;

endmodule

@@ rtl/mice_coord.sv @@
// ----------------------------------------------------------------------------
// Mic-E coordinate lane
// Seven-stage pipeline splitting a signed angle in 1e-7 degrees into whole
// degrees, whole minutes and hundredths of a minute, plus sign flags.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mice_coord (
  input  logic                 clk_i,
  input  logic signed [31:0]   coord_i,
  output mice_pkg::coord_res_t res_o
);
  import mice_pkg::*;

  logic [31:0] mag_d, mag1_q, mag2_q;
  logic [1:0]  flg_d;
  logic [1:0]  flg_q [1:6];
  logic [7:0]  deg_q [2:6];
  logic [63:0] prod2;
  logic [31:0] rem_full;
  logic [23:0] rem3_q;
  logic [25:0] m6_q;
  logic [52:0] prod5;
  logic [12:0] t5_q, t6_q;
  logic [26:0] prod6;
  logic [5:0]  tq6_q;
  logic [12:0] hund_full;
  coord_res_t  res_q;

  // Stage 1: magnitude and sign flags {pos, neg}
  assign mag_d = coord_i[31] ? (~$unsigned(coord_i) + 32'd1) : $unsigned(coord_i);
  assign flg_d = {~coord_i[31] & (coord_i != 32'sd0), coord_i[31]};

  // Stage 2: degrees by reciprocal multiply
  assign prod2 = 64'(mag1_q) * 64'(RecipDeg);

  // Stage 3: fraction of a degree
  assign rem_full = mag2_q - 32'(deg_q[2]) * DegScale;

  // Stage 5: minutes times 100 (value < 6000)
  assign prod5 = 53'(m6_q) * 53'(RecipMin);

  // Stage 6: whole minutes
  assign prod6 = 27'(t5_q) * 27'(Recip100T);

  // Stage 7: hundredths of a minute
  assign hund_full = t6_q - 13'(tq6_q) * 13'd100;

  always_ff @(posedge clk_i) begin
    mag1_q   <= mag_d;
    flg_q[1] <= flg_d;

    mag2_q   <= mag1_q;
    deg_q[2] <= prod2[62:55];
    flg_q[2] <= flg_q[1];

    rem3_q   <= rem_full[23:0];

    // six times the fraction by shift and add
    m6_q     <= {rem3_q, 2'b00} + {1'b0, rem3_q, 1'b0};

    t5_q     <= prod5[52:40];

    t6_q     <= t5_q;
    tq6_q    <= prod6[25:20];

    for (int i = 3; i <= 6; i++) begin
      deg_q[i] <= deg_q[i-1];
      flg_q[i] <= flg_q[i-1];
    end

    res_q.deg  <= deg_q[6];
    res_q.mins <= tq6_q;
    res_q.hund <= hund_full[6:0];
    res_q.pos  <= flg_q[6][1];
    res_q.neg  <= flg_q[6][0];
  end

  assign res_o = res_q;

endmodule

@@ rtl/mice_motion.sv @@
// ----------------------------------------------------------------------------
// Mic-E motion lane
// Seven-stage pipeline for the speed and course digits and the base-91
// altitude digits over the 10 km datum.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mice_motion (
  input  logic                  clk_i,
  input  logic [12:0]           speed_i,
  input  logic [15:0]           heading_i,
  input  logic signed [27:0]    altitude_i,
  output mice_pkg::motion_res_t res_o
);
  import mice_pkg::*;

  logic [12:0] spd1_q;
  logic [15:0] hdg1_q;
  logic [27:0] amag1_q;
  logic        aneg1_q, aneg2_q;

  logic [26:0] p_kn, p_sh;
  logic [32:0] p_h;
  logic [55:0] p_a;
  logic [9:0]  knots2_q, h2_q, h3_q;
  logic [6:0]  sh2_q, sh3_q;
  logic [20:0] m2_q;

  logic [9:0]         ku_full;
  logic [20:0]        p_hh;
  logic signed [22:0] alt_s;
  logic [19:0]        av_d, av3_q, av4_q;
  logic [3:0]         ku3_q;
  logic [2:0]         hh3_q;

  logic [9:0]  hr_full;
  logic [40:0] p_q1;
  logic [13:0] q1_4_q, q1_5_q;

  logic [19:0] lo_full;
  logic [28:0] p_q2;
  logic [6:0]  q2_5_q;
  logic [13:0] mid_full;

  motion_res_t res4_d, res4_q, res5_d, res5_q, res6_d, res6_q, res7_q;

  // Stage 2: reciprocal divides
  assign p_kn = 27'(spd1_q) * 27'(Recip10Spd);
  assign p_sh = 27'(spd1_q) * 27'(Recip100T);
  assign p_h  = 33'(hdg1_q) * 33'(Recip100Hdg);
  assign p_a  = 56'(amag1_q) * 56'(RecipAlt);

  // Stage 3: knot units, course thousands, signed altitude with saturation
  assign ku_full = knots2_q - 10'(sh2_q) * 10'd10;
  assign p_hh    = 21'(h2_q) * 21'(Recip100Sm);

  always_comb begin
    alt_s = aneg2_q ? (AltDatum - $signed({2'b00, m2_q}))
                    : (AltDatum + $signed({2'b00, m2_q}));
    priority if (alt_s < 23'sd0) begin
      av_d = '0;
    end else if (alt_s > $signed({3'b000, AltMax})) begin
      av_d = AltMax;
    end else begin
      av_d = alt_s[19:0];
    end
  end

  // Stage 4: course remainder, first base-91 divide
  assign hr_full = h3_q - 10'(hh3_q) * 10'd100;
  assign p_q1    = 41'(av3_q) * 41'(Recip91);

  always_comb begin
    res4_d            = '0;
    res4_d.spd_hund   = sh3_q;
    res4_d.knot_units = ku3_q;
    res4_d.hdg_thou   = hh3_q;
    res4_d.hdg_rem    = hr_full[6:0];
  end

  // Stage 5: low digit, second base-91 divide
  assign lo_full = av4_q - 20'(q1_4_q) * 20'd91;
  assign p_q2    = 29'(q1_4_q) * 29'(Recip91Sm);

  always_comb begin
    res5_d        = res4_q;
    res5_d.alt_lo = lo_full[6:0];
  end

  // Stage 6: middle and high digits
  assign mid_full = q1_5_q - 14'(q2_5_q) * 14'd91;

  always_comb begin
    res6_d         = res5_q;
    res6_d.alt_mid = mid_full[6:0];
    res6_d.alt_hi  = q2_5_q;
  end

  always_ff @(posedge clk_i) begin
    spd1_q  <= speed_i;
    hdg1_q  <= heading_i;
    amag1_q <= altitude_i[27] ? (~$unsigned(altitude_i) + 28'd1) : $unsigned(altitude_i);
    aneg1_q <= altitude_i[27];

    knots2_q <= p_kn[26:17];
    sh2_q    <= p_sh[26:20];
    h2_q     <= p_h[32:23];
    m2_q     <= p_a[54:34];
    aneg2_q  <= aneg1_q;

    ku3_q <= ku_full[3:0];
    sh3_q <= sh2_q;
    hh3_q <= p_hh[19:17];
    h3_q  <= h2_q;
    av3_q <= av_d;

    res4_q <= res4_d;
    q1_4_q <= p_q1[40:27];
    av4_q  <= av3_q;

    res5_q <= res5_d;
    q2_5_q <= p_q2[27:21];
    q1_5_q <= q1_4_q;

    res6_q <= res6_d;

    res7_q <= res6_q;
  end

  assign res_o = res7_q;

endmodule

@@ rtl/mic_e_position_encoder_top.sv @@
// ----------------------------------------------------------------------------
// Mic-E position encoder
// Encodes one position fix per clock into the 6-character Mic-E destination
// address and the 13-character Mic-E information field.
//
// Usage: a fix is taken at every clock edge with start high (busy is always
// low), so a new fix may follow in each cycle. Its result appears on the
// output ports with done_o high and stays for one cycle only; the receiver
// must take it then. The pipeline is seven lane stages (the reciprocal
// multiplies that split degrees, minutes and base-91 altitude digits), a
// decimal digit stage and the output register. The symbol characters come
// from the APB registers at the time the result leaves the block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mic_e_position_encoder_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // command channel
  input  logic                           start,
  output logic                           busy,
  input  logic signed [30:0]             latitude_i,
  input  logic signed [31:0]             longitude_i,
  input  logic [12:0]                    speed_i,
  input  logic [15:0]                    heading_i,
  input  logic signed [27:0]             altitude_i,
  // results
  output logic                           done_o,
  output logic [47:0]                    dest_chars_o,
  output logic [63:0]                    info_head_o,
  output logic [39:0]                    info_tail_o,
  // APB configuration
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [mice_pkg::CfgAddrW-1:0]  paddr,
  input  logic [mice_pkg::CfgDataW-1:0]  pwdata,
  output logic [mice_pkg::CfgDataW-1:0]  prdata,
  output logic                           pready
);
  import mice_pkg::*;

  cfg_t        cfg;
  coord_res_t  lat_res, lon_res;
  motion_res_t mot_res;

  logic [PipeDepth-1:0] vld_q;

  coord_res_t  lat8_q, lon8_q;
  motion_res_t mot8_q;
  logic [4:0]  qdeg8_q, qmin8_q, qhun8_q;

  logic [7:0]  deg_u, min_u, hun_u, londeg;
  logic [7:0]  d0, d1, d2, d3, d4, d5;
  logic [7:0]  c1, c2, c3, c4, c5, c6, c7, c8, c9, c10, c11;
  logic [47:0] dest_d, dest_q;
  logic [63:0] head_d, head_q;
  logic [39:0] tail_d, tail_q;

  assign busy = 1'b0;

  mice_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  mice_coord u_lat (
    .clk_i   (clk_i),
    .coord_i (32'(latitude_i)),
    .res_o   (lat_res)
  );

  mice_coord u_lon (
    .clk_i   (clk_i),
    .coord_i (longitude_i),
    .res_o   (lon_res)
  );

  mice_motion u_motion (
    .clk_i      (clk_i),
    .speed_i    (speed_i),
    .heading_i  (heading_i),
    .altitude_i (altitude_i),
    .res_o      (mot_res)
  );

  // Valid bits travel alongside the lanes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[PipeDepth-2:0], start & ~busy};
    end
  end

  // Stage 8: tens digits of the latitude fields
  always_ff @(posedge clk_i) begin
    lat8_q  <= lat_res;
    lon8_q  <= lon_res;
    mot8_q  <= mot_res;
    qdeg8_q <= div10(lat_res.deg);
    qmin8_q <= div10({2'b00, lat_res.mins});
    qhun8_q <= div10({1'b0, lat_res.hund});
  end

  // Stage 9: character assembly
  assign deg_u  = lat8_q.deg - 8'(qdeg8_q) * 8'd10;
  assign min_u  = 8'(lat8_q.mins) - 8'(qmin8_q) * 8'd10;
  assign hun_u  = 8'(lat8_q.hund) - 8'(qhun8_q) * 8'd10;
  assign londeg = lon8_q.deg;

  assign d0 = CharP + 8'(qdeg8_q);
  assign d1 = CharP + deg_u;
  assign d2 = Char0 + 8'(qmin8_q);
  assign d3 = Char0 + min_u + (lat8_q.pos ? FlagOfs : 8'd0);
  assign d4 = Char0 + 8'(qhun8_q)
            + (((londeg <= 8'd9) || (londeg >= 8'd100)) ? FlagOfs : 8'd0);
  assign d5 = Char0 + hun_u + (lon8_q.neg ? FlagOfs : 8'd0);

  // longitude degrees byte
  always_comb begin
    priority if (londeg <= 8'd9) begin
      c1 = londeg + LonOfsLo;
    end else if (londeg <= 8'd99) begin
      c1 = londeg + LonOfsMid;
    end else if (londeg <= 8'd109) begin
      c1 = londeg + LonOfsHi;
    end else begin
      c1 = londeg - LonOfsTop;
    end
  end

  assign c2  = 8'(lon8_q.mins) + ((lon8_q.mins <= 6'd9) ? MinOfsLo : MinOfsHi);
  assign c3  = 8'(lon8_q.hund) + ByteOfs;
  assign c4  = ByteOfs + 8'(mot8_q.spd_hund);
  assign c5  = ByteOfs + 8'(mot8_q.knot_units) * 8'd10 + 8'(mot8_q.hdg_thou);
  assign c6  = ByteOfs + 8'(mot8_q.hdg_rem);
  assign c7  = 8'(cfg.symbol_code);
  assign c8  = 8'(cfg.symbol_table);
  assign c9  = Base91Ofs + 8'(mot8_q.alt_hi);
  assign c10 = Base91Ofs + 8'(mot8_q.alt_mid);
  assign c11 = Base91Ofs + 8'(mot8_q.alt_lo);

  assign dest_d = {d0, d1, d2, d3, d4, d5};
  assign head_d = {CharTick, c1, c2, c3, c4, c5, c6, c7};
  assign tail_d = {c8, c9, c10, c11, CharBrace};

  always_ff @(posedge clk_i) begin
    dest_q <= dest_d;
    head_q <= head_d;
    tail_q <= tail_d;
  end

  assign done_o       = vld_q[PipeDepth-1];
  assign dest_chars_o = dest_q;
  assign info_head_o  = head_q;
  assign info_tail_o  = tail_q;

  // Every accepted fix leaves the pipeline with done_o high
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |-> ##PipeDepth done_o)
    else $error("fix did not produce a result after the pipeline latency");

  // Latitude tens digit stays within 'P'..'Z'
  a_lat_tens: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (dest_chars_o[47:40] >= CharP) && (dest_chars_o[47:40] <= CharP + 8'd10))
    else $error("latitude tens character out of range");

  // Altitude high digit after saturation stays within base-91 span
  a_alt_hi: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (info_tail_o[31:24] >= Base91Ofs) && (info_tail_o[31:24] <= 8'd124))
    else $error("altitude high digit out of range");

  // Symbol code on the result matches the register
  a_symbol: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (info_head_o[7:0] == 8'(cfg.symbol_code)))
    else $error("symbol code character does not match register");

endmodule

@@ tb/mic_e_position_encoder_checker.sv @@
// ----------------------------------------------------------------------------
// Mic-E encoder checker
// Watches the command, result and APB channels of the Mic-E position encoder.
// Tracks the symbol registers and predicts the destination address and the
// information field of every accepted fix. Each result is compared field by
// field with the oldest pending prediction; APB reads are checked as well.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mic_e_position_encoder_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // command channel
  input  logic                          start_i,
  input  logic                          busy_i,
  input  logic signed [30:0]            latitude_i,
  input  logic signed [31:0]            longitude_i,
  input  logic [12:0]                   speed_i,
  input  logic [15:0]                   heading_i,
  input  logic signed [27:0]            altitude_i,
  // results
  input  logic                          done_i,
  input  logic [47:0]                   dest_chars_i,
  input  logic [63:0]                   info_head_i,
  input  logic [39:0]                   info_tail_i,
  // APB
  input  logic                          psel_i,
  input  logic                          penable_i,
  input  logic                          pwrite_i,
  input  logic [mice_pkg::CfgAddrW-1:0] paddr_i,
  input  logic [mice_pkg::CfgDataW-1:0] pwdata_i,
  input  logic [mice_pkg::CfgDataW-1:0] prdata_i,
  input  logic                          pready_i,
  // status
  output int                            fail_count_o,
  output int                            pending_count_o
);
  import mice_pkg::*;

  typedef struct packed {
    logic [47:0] dest;
    logic [63:0] head;
    logic [39:0] tail;
  } mice_frame_t;

  logic [SymW-1:0] sym_code;
  logic [SymW-1:0] sym_table;
  mice_frame_t     pending_frames[$];

  // Mic-E encoding of one fix
  function automatic mice_frame_t encode_fix(input logic signed [30:0] lat,
                                             input logic signed [31:0] lon,
                                             input logic [12:0] spd,
                                             input logic [15:0] hdg,
                                             input logic signed [27:0] alt,
                                             input logic [SymW-1:0] code,
                                             input logic [SymW-1:0] tbl);
    logic [30:0]  lat_abs;
    logic [31:0]  lon_abs;
    logic [27:0]  alt_abs;
    int unsigned  lat_mag, lon_mag, deg, mins, lon_deg, knots, v;
    int           alt_m;
    logic [7:0]   d[6];
    logic [7:0]   c[13];
    mice_frame_t  f;
    lat_abs = lat[30] ? 31'(-lat) : lat;
    lon_abs = lon[31] ? 32'(-lon) : lon;
    alt_abs = alt[27] ? 28'(-alt) : alt;
    lat_mag = 32'(lat_abs);
    lon_mag = lon_abs;

    // destination: latitude digits and flags
    deg  = lat_mag / DegScale;
    d[0] = 8'(CharP + deg / 10);
    d[1] = 8'(CharP + deg % 10);
    mins = 6 * (lat_mag % DegScale);
    d[2] = 8'(Char0 + (mins / 10000000) % 10);
    d[3] = 8'(Char0 + (mins / 1000000) % 10);
    d[4] = 8'(Char0 + (mins / 100000) % 10);
    d[5] = 8'(Char0 + (mins / 10000) % 10);
    if (!lat[30] && lat_mag != 0) d[3] = d[3] + FlagOfs;  // north
    if (lon[31]) d[5] = d[5] + FlagOfs;                   // west
    lon_deg = lon_mag / DegScale;
    if (lon_deg <= 9 || lon_deg >= 100) d[4] = d[4] + FlagOfs;

    // information field: longitude
    c[0] = CharTick;
    if (lon_deg <= 9) c[1] = 8'(lon_deg + LonOfsLo);
    else if (lon_deg <= 99) c[1] = 8'(lon_deg + LonOfsMid);
    else if (lon_deg <= 109) c[1] = 8'(lon_deg + LonOfsHi);
    else c[1] = 8'(lon_deg - LonOfsTop);
    mins = 6 * (lon_mag % DegScale);
    v    = mins / 1000000;
    c[2] = (v <= 9) ? 8'(v + MinOfsLo) : 8'(v + MinOfsHi);
    c[3] = 8'((mins / 10000) % 100 + ByteOfs);

    // speed and course
    knots = spd / 10;
    c[4] = 8'(ByteOfs + knots / 10);
    c[5] = 8'(ByteOfs + (knots % 10) * 10 + hdg / 10000);
    c[6] = 8'(ByteOfs + (hdg / 100) % 100);
    c[7] = 8'(code);
    c[8] = 8'(tbl);

    // altitude in base 91 over the datum, saturated
    alt_m = int'(32'(alt_abs) / 100);
    if (alt[27]) alt_m = -alt_m;
    alt_m = alt_m + int'(AltDatum);
    if (alt_m < 0) alt_m = 0;
    if (alt_m > int'(AltMax)) alt_m = int'(AltMax);
    v     = alt_m;
    c[9]  = 8'(Base91Ofs + v / 8281);
    c[10] = 8'(Base91Ofs + (v / 91) % 91);
    c[11] = 8'(Base91Ofs + v % 91);
    c[12] = CharBrace;

    f.dest = {d[0], d[1], d[2], d[3], d[4], d[5]};
    f.head = {c[0], c[1], c[2], c[3], c[4], c[5], c[6], c[7]};
    f.tail = {c[8], c[9], c[10], c[11], c[12]};
    return f;
  endfunction

  task automatic check_field(input string name, input logic [63:0] exp_v,
                             input logic [63:0] act_v);
    if (act_v !== exp_v) begin
      fail_count_o++;
      $display("%0t: %s mismatch: expected %h actual %h", $time, name, exp_v, act_v);
    end
  endtask

  // Channel monitor, sampled at the rising edge
  always @(posedge clk_i or negedge rst_ni) begin
    mice_frame_t want;
    if (!rst_ni) begin
      sym_code  = SymCodeRst;
      sym_table = SymTableRst;
      pending_frames.delete();
    end else begin
      // register traffic
      if (psel_i && penable_i && pready_i) begin
        if (pwrite_i) begin
          case (paddr_i >> 2)
            RegSymbolCode:  sym_code  = pwdata_i[SymW-1:0];
            RegSymbolTable: sym_table = pwdata_i[SymW-1:0];
            default: ;
          endcase
        end else begin
          case (paddr_i >> 2)
            RegSymbolCode:  check_field("symbol_code read", 64'(sym_code), 64'(prdata_i));
            RegSymbolTable: check_field("symbol_table read", 64'(sym_table), 64'(prdata_i));
            default: ;
          endcase
        end
      end

      // results
      if (done_i) begin
        if (pending_frames.size() == 0) begin
          fail_count_o++;
          $display("%0t: result with no fix pending: actual %h %h %h", $time,
                   dest_chars_i, info_head_i, info_tail_i);
        end else begin
          want = pending_frames.pop_front();
          check_field("dest_chars", 64'(want.dest), 64'(dest_chars_i));
          check_field("info_head", want.head, info_head_i);
          check_field("info_tail", 64'(want.tail), 64'(info_tail_i));
        end
      end

      // accepted fixes
      if (start_i && !busy_i)
        pending_frames.push_back(encode_fix(latitude_i, longitude_i, speed_i, heading_i,
                                            altitude_i, sym_code, sym_table));
    end
    pending_count_o = pending_frames.size();
  end

  initial begin
    fail_count_o    = 0;
    pending_count_o = 0;
  end

endmodule

@@ tb/mic_e_position_encoder_top_tb.sv @@
// ----------------------------------------------------------------------------
// Mic-E encoder testbench
// Drives position fixes and APB register traffic into the Mic-E position
// encoder: a directed set of edge cases, then random fixes under several
// symbol settings with random sender gaps and drain pauses. The checker
// beside the block predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mic_e_position_encoder_top_tb;
  import mice_pkg::*;

  localparam int PhaseFixes = 220;
  localparam int CycleLimit = 300000;

  typedef struct {
    logic signed [30:0] lat;
    logic signed [31:0] lon;
    logic [12:0]        spd;
    logic [15:0]        hdg;
    logic signed [27:0] alt;
  } fix_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  logic signed [30:0]  latitude_i = '0;
  logic signed [31:0]  longitude_i = '0;
  logic [12:0]         speed_i = '0;
  logic [15:0]         heading_i = '0;
  logic signed [27:0]  altitude_i = '0;
  logic                done_o;
  logic [47:0]         dest_chars_o;
  logic [63:0]         info_head_o;
  logic [39:0]         info_tail_o;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [CfgAddrW-1:0] paddr = '0;
  logic [CfgDataW-1:0] pwdata = '0;
  logic [CfgDataW-1:0] prdata;
  logic                pready;
  int                  fail_count;
  int                  pending_count;
  int                  cycle_count = 0;
  int                  gap_mode = 1;

  always #10 clk_i = ~clk_i;

  mic_e_position_encoder_top i_dut (
    .clk_i, .rst_ni, .start, .busy,
    .latitude_i, .longitude_i, .speed_i, .heading_i, .altitude_i,
    .done_o, .dest_chars_o, .info_head_o, .info_tail_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  mic_e_position_encoder_checker i_checker (
    .clk_i, .rst_ni,
    .start_i(start), .busy_i(busy),
    .latitude_i, .longitude_i, .speed_i, .heading_i, .altitude_i,
    .done_i(done_o), .dest_chars_i(dest_chars_o), .info_head_i(info_head_o),
    .info_tail_i(info_tail_o),
    .psel_i(psel), .penable_i(penable), .pwrite_i(pwrite), .paddr_i(paddr),
    .pwdata_i(pwdata), .prdata_i(prdata), .pready_i(pready),
    .fail_count_o(fail_count), .pending_count_o(pending_count)
  );

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  function automatic fix_t mk_fix(input longint lat, input longint lon, input int spd,
                                  input int hdg, input longint alt);
    fix_t f;
    f.lat = 31'(lat);
    f.lon = 32'(lon);
    f.spd = 13'(spd);
    f.hdg = 16'(hdg);
    f.alt = 28'(alt);
    return f;
  endfunction

  // Mostly in-range values, some full-width ones, longitudes near the code bands
  function automatic fix_t rand_fix();
    int     boundary_deg[8] = '{0, 9, 10, 99, 100, 109, 110, 180};
    longint lon;
    fix_t   f;
    f.lat = ($urandom_range(0, 7) == 0) ? 31'($urandom)
          : 31'(longint'($urandom_range(0, 1800000000)) - 900000000);
    case ($urandom_range(0, 7))
      0: lon = longint'($signed($urandom));
      1, 2: begin
        lon = longint'(boundary_deg[$urandom_range(0, 7)]) * 10000000
            + $urandom_range(0, 9999999);
        if ($urandom_range(0, 1)) lon = -lon;
      end
      default: lon = longint'($urandom_range(0, 32'd3600000000)) - 1800000000;
    endcase
    f.lon = 32'(lon);
    f.spd = ($urandom_range(0, 7) == 0) ? 13'($urandom) : 13'($urandom_range(0, 7999));
    f.hdg = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 35999));
    f.alt = ($urandom_range(0, 7) == 0) ? 28'($urandom)
          : 28'(longint'($urandom_range(0, 75357099)) - 1000000);
    return f;
  endfunction

  // Called and returning at a falling edge; start stays high after acceptance
  task automatic send_fix(input fix_t f, input int gap);
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) begin
        latitude_i  = 31'($urandom);
        longitude_i = $urandom;
        @(negedge clk_i);
      end
    end
    latitude_i  = f.lat;
    longitude_i = f.lon;
    speed_i     = f.spd;
    heading_i   = f.hdg;
    altitude_i  = f.alt;
    start       = 1'b1;
    do @(posedge clk_i); while (busy);
    @(negedge clk_i);
  endtask

  function automatic int draw_gap();
    case (gap_mode)
      0: return 0;
      1: return $urandom_range(0, 13);
      default: return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 13) : 0;
    endcase
  endfunction

  task automatic wait_drained();
    start = 1'b0;
    while (pending_count != 0) @(negedge clk_i);
  endtask

  task automatic apb_access(input logic write, input cfg_reg_e r,
                            input logic [CfgDataW-1:0] data);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = write;
    paddr   = CfgAddrW'(r) << 2;
    pwdata  = data;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  task automatic set_symbols(input logic [SymW-1:0] code, input logic [SymW-1:0] tbl,
                             input logic junk_hi);
    logic [CfgDataW-1:0] hi;
    hi = junk_hi ? $urandom : '0;
    apb_access(1'b1, RegSymbolCode, {hi[CfgDataW-1:SymW], code});
    hi = junk_hi ? $urandom : '0;
    apb_access(1'b1, RegSymbolTable, {hi[CfgDataW-1:SymW], tbl});
    apb_access(1'b0, RegSymbolCode, '0);
    apb_access(1'b0, RegSymbolTable, '0);
  endtask

  task automatic random_phase(input int count);
    for (int i = 0; i < count; i++) begin
      if (i % 32 == 0) gap_mode = $urandom_range(0, 2);
      // occasional full drain before the next fix
      if ($urandom_range(0, 63) == 0) wait_drained();
      send_fix(rand_fix(), draw_gap());
    end
    wait_drained();
  endtask

  // Stimulus and verdict
  initial begin
    logic [SymW-1:0] rc, rt;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // reset values read back
    apb_access(1'b0, RegSymbolCode, '0);
    apb_access(1'b0, RegSymbolTable, '0);

    // directed: zero fix, latitude and longitude extremes, code bands, rate limits
    send_fix(mk_fix(0, 0, 0, 0, 0), 0);
    send_fix(mk_fix(900000000, 1800000000, 7999, 35999, 74357099), 0);
    send_fix(mk_fix(-900000000, -1800000000, 0, 0, -1000000), 3);
    send_fix(mk_fix(1, -1, 10, 100, -99), 0);
    send_fix(mk_fix(-1, 1, 9, 99, 99), 1);
    send_fix(mk_fix(1073741823, 2147483647, 8191, 65535, 134217727), 0);
    send_fix(mk_fix(-1073741824, -2147483648, 8191, 65535, -134217728), 0);
    send_fix(mk_fix(123456789, 99999999, 1234, 12345, 74357199), 2);
    send_fix(mk_fix(-123456789, 100000000, 555, 20000, -1000001), 0);
    send_fix(mk_fix(456789012, -999999999, 4321, 30000, 100), 0);
    send_fix(mk_fix(-456789012, 1000000000, 7000, 35999, -100), 5);
    send_fix(mk_fix(899999999, -1099999999, 800, 9999, 50000000), 0);
    send_fix(mk_fix(-899999999, 1100000000, 1, 1, -999999), 0);
    send_fix(mk_fix(10000000, -1799999999, 99, 10000, 1), 0);
    send_fix(mk_fix(-10000000, 1500000, 100, 65000, 74357100), 13);
    send_fix(mk_fix(333333333, -16666666, 6789, 31415, 1234567), 0);
    send_fix(mk_fix(0, 1999999999, 8000, 40000, -1), 0);
    send_fix(mk_fix(9999999, -90000000, 5000, 18000, 2000000), 0);
    wait_drained();

    // random fixes under several symbol settings, extremes first
    set_symbols(7'd33, 7'd126, 1'b0);
    random_phase(PhaseFixes);
    set_symbols(7'd126, 7'd33, 1'b0);
    random_phase(PhaseFixes);
    set_symbols(7'd0, 7'd127, 1'b1);
    random_phase(PhaseFixes);
    set_symbols(7'd127, 7'd0, 1'b0);
    random_phase(PhaseFixes);
    rc = 7'($urandom_range(33, 126));
    rt = 7'($urandom_range(33, 126));
    set_symbols(rc, rt, 1'b1);
    random_phase(PhaseFixes);

    // let any stray result show up
    repeat (PipeDepth + 4) @(negedge clk_i);
    if (fail_count == 0 && pending_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/mice_pkg.sv
rtl/mice_cfg.sv
rtl/mice_coord.sv
rtl/mice_motion.sv
rtl/mic_e_position_encoder_top.sv
tb/mic_e_position_encoder_checker.sv
tb/mic_e_position_encoder_top_tb.sv
